>>> hw/rtl/dmxrdm_pkg.sv
package dmxrdm_pkg;

	localparam int FRAME_BYTES = 513;
	localparam int SLOT_W      = 10;
	localparam int SUM_W       = 16;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [7:0] SC_NULL = 8'h00;
	localparam logic [7:0] SC_RDM  = 8'hCC;
	localparam logic [7:0] SC_DISC = 8'hFE;

	// register index 0: rdm_external_handling
	localparam logic REG_RDM_EXT = 1'b0;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_BREAK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_DMX         = 2'd0,
		KIND_RDM_GOOD    = 2'd1,
		KIND_RDM_BAD     = 2'd2,
		KIND_UNDELIVERED = 2'd3
	} kind_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
	} evt_t;

	typedef struct packed {
		logic              byte_valid;
		logic [SLOT_W-1:0] slot_index;
		logic [7:0]        slot_value;
		logic              frame_done;
		kind_t             frame_kind;
		logic [SLOT_W-1:0] frame_slots;
	} res_t;

	// framer -> output stage
	typedef struct packed {
		logic emit;
		res_t data;
	} fr_out_t;

endpackage

>>> hw/rtl/dmxrdm_apb_regs.sv
module dmxrdm_apb_regs
	import dmxrdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic              rdm_ext
);

	logic rdm_ext_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdm_ext_q <= 1'b0;
		end else if (wr_en && (paddr[2] == REG_RDM_EXT)) begin
			rdm_ext_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_RDM_EXT: prdata = {{(DATA_W-1){1'b0}}, rdm_ext_q};
			default:     prdata = '0;
		endcase
	end

	assign rdm_ext = rdm_ext_q;

endmodule

>>> hw/rtl/dmxrdm_in_stage.sv
module dmxrdm_in_stage
	import dmxrdm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  evt_t evt,
	input  logic take,
	output logic valid_s1,
	output evt_t evt_s1
);

	logic accept;

	// hold only while the held request cannot move on
	assign evt_stall = valid_s1 && !take;
	assign accept    = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1 <= evt;
		end
	end

endmodule

>>> hw/rtl/dmxrdm_framer.sv
module dmxrdm_framer
	import dmxrdm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  evt_t    evt_s1,
	input  logic    rdm_ext,
	output fr_out_t fr_out
);

	logic              receiving_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [SLOT_W-1:0] exp_len_q;
	logic [7:0]        start_code_q;
	logic [7:0]        len_byte_q;
	logic [SUM_W-1:0]  sum_q;
	logic [7:0]        chk_hi_q;

	logic [7:0]        c;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] nxt;
	logic [7:0]        sc_new;
	logic [SUM_W-1:0]  sum_new;
	logic [7:0]        chk_hi_new;
	logic [7:0]        len_new;
	logic [SLOT_W-1:0] exp_new;
	logic [SLOT_W-1:0] len_p2;
	logic              rcv_new;
	logic              in_sum;
	logic              complete;
	logic              good;

	assign c    = evt_s1.data_byte;
	assign slot = next_slot_q;
	assign nxt  = slot + SLOT_W'(1);

	always_comb begin
		sc_new     = (slot == '0) ? c : start_code_q;
		in_sum     = (slot < SLOT_W'(3)) || (slot < {2'b00, len_byte_q});
		sum_new    = in_sum ? (sum_q + {8'h00, c}) : sum_q;
		chk_hi_new = (!in_sum && (slot == {2'b00, len_byte_q})) ? c : chk_hi_q;
		len_new    = (slot == SLOT_W'(2)) ? c : len_byte_q;
		len_p2     = {2'b00, c} + SLOT_W'(2);
		exp_new    = exp_len_q;
		rcv_new    = receiving_q;

		// slot 2 fixes the frame length
		if (slot == SLOT_W'(2)) begin
			if (sc_new == SC_RDM) begin
				if (!rdm_ext) begin
					exp_new = (len_p2 > SLOT_W'(FRAME_BYTES)) ? SLOT_W'(FRAME_BYTES) : len_p2;
				end
			end else if (sc_new == SC_DISC) begin
				exp_new = SLOT_W'(FRAME_BYTES);
			end else if (sc_new != SC_NULL) begin
				rcv_new = 1'b0;
			end
		end

		complete = rcv_new && (nxt >= exp_new);
		good = (len_new >= 8'd3) && (slot == ({2'b00, len_new} + SLOT_W'(1))) &&
			(chk_hi_new == sum_new[15:8]) && (c == sum_new[7:0]);

		fr_out = '0;
		if (evt_s1.op == OP_BREAK) begin
			// a break closes a pending DMX frame with more than one slot
			fr_out.emit = receiving_q && (next_slot_q > SLOT_W'(1)) &&
				(start_code_q == SC_NULL);
			fr_out.data.frame_done  = fr_out.emit;
			fr_out.data.frame_kind  = (fr_out.emit && rdm_ext) ? KIND_UNDELIVERED
				: KIND_DMX;
			fr_out.data.frame_slots = fr_out.emit ? (next_slot_q - SLOT_W'(1)) : '0;
		end else begin
			fr_out.emit            = receiving_q;
			fr_out.data.byte_valid = 1'b1;
			fr_out.data.slot_index = slot;
			fr_out.data.slot_value = c;
			if (complete) begin
				fr_out.data.frame_done = 1'b1;
				if (sc_new == SC_NULL) begin
					fr_out.data.frame_kind  = rdm_ext ? KIND_UNDELIVERED : KIND_DMX;
					fr_out.data.frame_slots = slot;
				end else if ((sc_new == SC_RDM) && !rdm_ext) begin
					fr_out.data.frame_kind  = good ? KIND_RDM_GOOD : KIND_RDM_BAD;
					fr_out.data.frame_slots = nxt;
				end else begin
					fr_out.data.frame_kind  = KIND_UNDELIVERED;
					fr_out.data.frame_slots = nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q  <= 1'b0;
			next_slot_q  <= '0;
			exp_len_q    <= SLOT_W'(FRAME_BYTES);
			start_code_q <= '0;
			len_byte_q   <= '0;
			sum_q        <= '0;
			chk_hi_q     <= '0;
		end else if (fire) begin
			if (evt_s1.op == OP_BREAK) begin
				receiving_q <= 1'b1;
				next_slot_q <= '0;
				exp_len_q   <= SLOT_W'(FRAME_BYTES);
				len_byte_q  <= '0;
				sum_q       <= '0;
				chk_hi_q    <= '0;
			end else if (receiving_q) begin
				receiving_q  <= rcv_new && !complete;
				next_slot_q  <= nxt;
				exp_len_q    <= exp_new;
				start_code_q <= sc_new;
				len_byte_q   <= len_new;
				sum_q        <= sum_new;
				chk_hi_q     <= chk_hi_new;
			end
		end
	end

endmodule

>>> hw/rtl/dmxrdm_out_stage.sv
module dmxrdm_out_stage
	import dmxrdm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  fr_out_t fr_out,
	output logic    free,
	output logic    res_valid,
	input  logic    res_stall,
	output res_t    res
);

	logic res_valid_q;
	res_t res_q;

	assign free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && fr_out.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && fr_out.emit) begin
			res_q <= fr_out.data;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hw/rtl/dmx_rdm_receive_framer_core.sv
// Channel   Handshake                      Payload   Direction
// event     evt_valid / evt_stall          evt       UART byte or break in
// result    res_valid / res_stall          res       slot byte / frame report out
// config    psel penable pwrite pready     pwdata    APB write/read, reg 0 at 0x0
//
// One event request accepted per cycle while the result channel is not stalled. An event
//   passes the input register, then framer logic into the result register.
// An event that yields no result (idle byte, quiet break) still passes through the input register.
// arst_n clears all framer state; receiving starts at the first break.
// A stalled result holds the result register; the input register then fills
//   and evt_stall rises, so at most two requests sit in the block.
module dmx_rdm_receive_framer_core
	import dmxrdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// event channel
	input  logic              evt_valid,
	output logic              evt_stall,
	input  evt_t              evt,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic    rdm_ext;
	logic    valid_s1;
	evt_t    evt_s1;
	logic    free;
	logic    fire;
	fr_out_t fr_out;

	// the held event is processed once the result register can take its outcome
	assign fire = valid_s1 && free;

	dmxrdm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rdm_ext (rdm_ext)
	);

	dmxrdm_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.take      (fire),
		.valid_s1  (valid_s1),
		.evt_s1    (evt_s1)
	);

	// slot counting, length capture, checksum and completion reporting
	dmxrdm_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.evt_s1  (evt_s1),
		.rdm_ext (rdm_ext),
		.fr_out  (fr_out)
	);

	dmxrdm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.fr_out    (fr_out),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

>>> hw/rtl/dmxrdm_checker.sv
module dmxrdm_checker
	import dmxrdm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res,
	input logic pready
);

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// a result without a slot byte can only be a break closing a frame
	a_break_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.byte_valid |-> res.frame_done &&
			res.slot_index == '0 && res.slot_value == '0)
		else $error("break result without completion");

	a_idle_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.frame_done |-> res.frame_kind == KIND_DMX &&
			res.frame_slots == '0)
		else $error("frame fields set without completion");

	a_dmx_slots: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_done && res.frame_kind == KIND_DMX |->
			res.frame_slots != '0)
		else $error("empty DMX frame reported");

endmodule

bind dmx_rdm_receive_framer_core dmxrdm_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res),
	.pready    (pready)
);
